@@ design/plc_pkg.sv @@
package plc_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  typedef logic [2:0] op_t;
  localparam op_t OP_APPEND    = 3'd0;
  localparam op_t OP_INSERT    = 3'd1;
  localparam op_t OP_READ      = 3'd2;
  localparam op_t OP_DELETE    = 3'd3;
  localparam op_t OP_SWAP      = 3'd4;
  localparam op_t OP_OVERWRITE = 3'd5;
  localparam op_t OP_CLEAR     = 3'd6;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_REJECT = 2'd1;
  localparam status_t ST_SAME   = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_WRITE
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             wr_b;
    logic [31:0]      data_a;
    logic [31:0]      data_b;
  } cell_ctrl_t;

  typedef struct packed {
    op_t                operation;
    logic [7:0]         position;
    logic [7:0]         position_b;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] read_value;
    logic [7:0]         count;
    logic               is_full;
    logic               is_empty;
  } out_t;

endpackage

@@ design/plc_cell.sv @@
module plc_cell
  import plc_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [31:0]      lower_i,
  input  logic [31:0]      upper_i,
  output logic [31:0]      value_o,
  output logic [31:0]      sel_a_o,
  output logic [31:0]      sel_b_o
);

  logic [31:0] value_q;
  logic [31:0] value_d;
  logic        hit_a;
  logic        hit_b;

  assign hit_a = (idx_i == ctrl_i.idx_a);
  assign hit_b = (idx_i == ctrl_i.idx_b);

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.cmd)
      CMD_HOLD: begin
        value_d = value_q;
      end
      CMD_INSERT: begin
        if (hit_a) begin
          value_d = ctrl_i.data_a;
        end else if (idx_i > ctrl_i.idx_a) begin
          value_d = lower_i;
        end
      end
      CMD_DELETE: begin
        if (idx_i >= ctrl_i.idx_a) begin
          value_d = upper_i;
        end
      end
      CMD_WRITE: begin
        if (hit_a) begin
          value_d = ctrl_i.data_a;
        end else if (hit_b && ctrl_i.wr_b) begin
          value_d = ctrl_i.data_b;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign sel_a_o = hit_a ? value_q : 32'd0;
  assign sel_b_o = hit_b ? value_q : 32'd0;

endmodule

@@ design/plc_select.sv @@
module plc_select
  import plc_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] sel_a_i [CAPACITY],
  input  logic [31:0] sel_b_i [CAPACITY],
  output logic [31:0] rd_a_o,
  output logic [31:0] rd_b_o
);

  logic [31:0] grp_a_d [NUM_GRP];
  logic [31:0] grp_b_d [NUM_GRP];
  logic [31:0] grp_a_q [NUM_GRP];
  logic [31:0] grp_b_q [NUM_GRP];
  logic [31:0] rd_a_d;
  logic [31:0] rd_b_d;
  logic [31:0] rd_a_q;
  logic [31:0] rd_b_q;

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_a_d[g] = 32'd0;
      grp_b_d[g] = 32'd0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_a_d[g] = grp_a_d[g] | sel_a_i[g * GRP_SIZE + k];
          grp_b_d[g] = grp_b_d[g] | sel_b_i[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    rd_a_d = 32'd0;
    rd_b_d = 32'd0;
    for (int g = 0; g < NUM_GRP; g++) begin
      rd_a_d = rd_a_d | grp_a_q[g];
      rd_b_d = rd_b_d | grp_b_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_a_q <= grp_a_d;
    grp_b_q <= grp_b_d;
    rd_a_q  <= rd_a_d;
    rd_b_q  <= rd_b_d;
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

@@ design/positional_list_store_top.sv @@
// Ordered list of up to CAPACITY signed 32-bit values, addressed by 1-based
// position, held in a row of cells that shift together on insert and delete.
// Input channel: in_valid_i, in_stall_o and in_data_i carry one operation per
// transaction (append, insert, read, delete, swap, overwrite, clear).
// Output channel: out_valid_o, out_stall_i and out_data_o carry one result
// per operation: status, read value, count and full and empty flags.
// One operation is in work at a time. After acceptance it passes through
// the group and result registers of the select tree (states S_RED1 and
// S_RED2), which fetch the addressed cells; then in S_EXEC the shift or
// write is applied to all cells at once and the result enters the output
// register. A new operation is not accepted before that result has been
// loaded, since the input is stalled until the result has been loaded.
// A result waiting in the output register does not hold off the next
// transaction; a stalled receiver holds the following operation in its
// final cycle until the output register frees.
// Reset empties the list and the output register; cell contents are left
// as they are and are never read before they are written.
module positional_list_store_top
  import plc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED1 = 2'd1;
  localparam logic [1:0] S_RED2 = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0]       state_q;
  logic [1:0]       state_d;
  in_t              item_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             out_valid_q;
  logic             out_valid_d;
  out_t             out_data_q;
  out_t             out_data_d;

  logic             in_accept;
  logic             out_load;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pa_ext;
  logic [CMP_W-1:0] pb_ext;
  logic             not_full;
  logic             pa_ok;
  logic             pb_ok;
  logic             ins_ok;
  logic [CMP_W-1:0] new_cnt_ext;
  status_t          status_d;
  logic [31:0]      rd_value;
  cell_ctrl_t       ctrl;

  logic [31:0] cell_val [CAPACITY];
  logic [31:0] sel_a    [CAPACITY];
  logic [31:0] sel_b    [CAPACITY];
  logic [31:0] rd_a;
  logic [31:0] rd_b;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign cnt_ext  = CMP_W'(count_q);
  assign pa_ext   = CMP_W'(item_q.position);
  assign pb_ext   = CMP_W'(item_q.position_b);
  assign not_full = (cnt_ext < CMP_W'(CAPACITY));
  assign pa_ok    = (pa_ext != '0) && (pa_ext <= cnt_ext);
  assign pb_ok    = (pb_ext != '0) && (pb_ext <= cnt_ext);
  assign ins_ok   = not_full && (pa_ext != '0) && (pa_ext <= cnt_ext + CMP_W'(1));

  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.idx_a  = IDX_W'(pa_ext - CMP_W'(1));
    ctrl.idx_b  = IDX_W'(pb_ext - CMP_W'(1));
    ctrl.wr_b   = 1'b0;
    ctrl.data_a = item_q.value;
    ctrl.data_b = rd_a;
    status_d    = ST_REJECT;
    rd_value    = 32'd0;
    count_d     = count_q;
    if (item_q.operation == OP_APPEND) begin
      ctrl.idx_a = IDX_W'(cnt_ext);
    end
    unique case (item_q.operation)
      OP_APPEND: begin
        if (not_full) begin
          ctrl.cmd = CMD_WRITE;
          status_d = ST_DONE;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (ins_ok) begin
          ctrl.cmd = CMD_INSERT;
          status_d = ST_DONE;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pa_ok) begin
          status_d = ST_DONE;
          rd_value = rd_a;
        end
      end
      OP_DELETE: begin
        if (pa_ok) begin
          ctrl.cmd = CMD_DELETE;
          status_d = ST_DONE;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_SWAP: begin
        if (pa_ok && pb_ok) begin
          if (pa_ext == pb_ext) begin
            status_d = ST_SAME;
          end else begin
            ctrl.cmd    = CMD_WRITE;
            ctrl.wr_b   = 1'b1;
            ctrl.data_a = rd_b;
            ctrl.data_b = rd_a;
            status_d    = ST_DONE;
          end
        end
      end
      OP_OVERWRITE: begin
        if (pa_ok) begin
          ctrl.cmd = CMD_WRITE;
          status_d = ST_DONE;
        end
      end
      OP_CLEAR: begin
        status_d = ST_DONE;
        count_d  = '0;
      end
      default: begin
        status_d = ST_REJECT;
      end
    endcase
    if (!out_load) begin
      ctrl.cmd = CMD_HOLD;
      count_d  = count_q;
    end
  end

  assign new_cnt_ext = CMP_W'(count_d);

  always_comb begin
    out_data_d.status     = status_d;
    out_data_d.read_value = rd_value;
    out_data_d.count      = new_cnt_ext[7:0];
    out_data_d.is_full    = (new_cnt_ext == CMP_W'(CAPACITY));
    out_data_d.is_empty   = (new_cnt_ext == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_RED1;
        end
      end
      S_RED1: begin
        state_d = S_RED2;
      end
      S_RED2: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [31:0] lower;
    logic [31:0] upper;
    if (i == 0) begin : g_first
      assign lower = 32'd0;
    end else begin : g_lower
      assign lower = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = 32'd0;
    end else begin : g_upper
      assign upper = cell_val[i+1];
    end
    plc_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .lower_i (lower),
      .upper_i (upper),
      .value_o (cell_val[i]),
      .sel_a_o (sel_a[i]),
      .sel_b_o (sel_b[i])
    );
  end

  plc_select u_select (
    .clk_i   (clk_i),
    .sel_a_i (sel_a),
    .sel_b_i (sel_b),
    .rd_a_o  (rd_a),
    .rd_b_o  (rd_b)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_ext <= CMP_W'(CAPACITY))
    else $error("element count exceeds capacity");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_RED1))
    else $error("accepted transaction did not start the select pass");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (status_d == ST_REJECT)) |=> (count_q == $past(count_q)))
    else $error("rejected transaction changed the element count");
`endif

endmodule
